>>> rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [WordW-1:0] H0Init = 32'h6745_2301;
  localparam logic [WordW-1:0] H1Init = 32'hEFCD_AB89;
  localparam logic [WordW-1:0] H2Init = 32'h98BA_DCFE;
  localparam logic [WordW-1:0] H3Init = 32'h1032_5476;
  localparam logic [WordW-1:0] H4Init = 32'hC3D2_E1F0;

  localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // One big-endian message word headed for the compression core
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             is_final;  // last word of the last block of a message
  } word_entry_t;

endpackage

>>> rtl/sha1_fifo.sv
`timescale 1ns / 1ps
// Short word queue between the byte front end and the compression core.
module sha1_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sha1_pkg::word_entry_t push_entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output sha1_pkg::word_entry_t pop_entry_o,
  output logic                 empty_o
);
  import sha1_pkg::*;

  word_entry_t         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o      = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o     = (cnt_q == '0);
  assign pop_entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("word queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("word queue underflow");

endmodule

>>> rtl/sha1_front.sv
`timescale 1ns / 1ps
// Byte front end: packs bytes into words and generates the message padding.
module sha1_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            message_byte_i,
  input  logic                  last_byte_i,
  output logic                  push_o,
  output sha1_pkg::word_entry_t push_entry_o,
  input  logic                  fifo_full_i
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    StCollect,
    StMark,
    StZero,
    StLenHi,
    StLenLo
  } state_e;

  state_e       state_q;
  logic [60:0]  cnt_q;
  logic [60:0]  len_q;
  logic [23:0]  part_q;
  logic [3:0]   widx_q;
  logic         accept;
  logic [1:0]   pos;
  logic [60:0]  cnt_inc;
  state_e       pad_next;

  assign in_stall_o = (state_q != StCollect) || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos        = cnt_q[1:0];
  assign cnt_inc    = cnt_q + 61'd1;
  // the length goes into words 14 and 15 of a block
  assign pad_next   = ((widx_q + 4'd1) == 4'd14) ? StLenHi : StZero;

  always_comb begin
    push_o                = 1'b0;
    push_entry_o.word     = '0;
    push_entry_o.is_final = 1'b0;
    unique case (state_q)
      StCollect: begin
        push_o = accept && ((pos == 2'd3) || last_byte_i);
        unique case (pos)
          2'd0:    push_entry_o.word = {message_byte_i, PadByte, 16'h0000};
          2'd1:    push_entry_o.word = {part_q[7:0], message_byte_i, PadByte, 8'h00};
          2'd2:    push_entry_o.word = {part_q[15:0], message_byte_i, PadByte};
          default: push_entry_o.word = {part_q, message_byte_i};
        endcase
      end
      StMark: begin
        push_o            = !fifo_full_i;
        push_entry_o.word = {PadByte, 24'h000000};
      end
      StZero: begin
        push_o = !fifo_full_i;
      end
      StLenHi: begin
        push_o            = !fifo_full_i;
        push_entry_o.word = len_q[60:29];
      end
      default: begin
        push_o                = !fifo_full_i;
        push_entry_o.word     = {len_q[28:0], 3'b000};
        push_entry_o.is_final = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
      cnt_q   <= '0;
      len_q   <= '0;
      part_q  <= '0;
      widx_q  <= '0;
    end else begin
      if (push_o) begin
        widx_q <= widx_q + 4'd1;
      end
      unique case (state_q)
        StCollect: begin
          if (accept) begin
            part_q <= {part_q[15:0], message_byte_i};
            if (last_byte_i) begin
              len_q   <= cnt_inc;
              cnt_q   <= '0;
              state_q <= (pos == 2'd3) ? StMark : pad_next;
            end else begin
              cnt_q <= cnt_inc;
            end
          end
        end
        StMark, StZero: begin
          if (push_o) begin
            state_q <= pad_next;
          end
        end
        StLenHi: begin
          if (push_o) begin
            state_q <= StLenLo;
          end
        end
        default: begin
          if (push_o) begin
            state_q <= StCollect;
          end
        end
      endcase
    end
  end

  a_count_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> (cnt_q == '0 && state_q != StCollect))
    else $error("byte count not restarted after last item");

endmodule

>>> rtl/sha1_core.sv
`timescale 1ns / 1ps
// Compression core: loads 16 words, runs 80 rounds, folds into the chain, emits digest.
module sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output logic                  pop_o,
  input  sha1_pkg::word_entry_t entry_i,
  input  logic                  empty_i,
  output logic [31:0]           digest_h0_o,
  output logic [31:0]           digest_h1_o,
  output logic [31:0]           digest_h2_o,
  output logic [31:0]           digest_h3_o,
  output logic [31:0]           digest_h4_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StAdd,
    StEmit
  } state_e;

  state_e           state_q;
  logic [WordW-1:0] w_q [16];
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [WordW-1:0] h_q [5];
  logic [WordW-1:0] dig_q [5];
  logic [6:0]       rnd_q;
  logic [3:0]       ld_cnt_q;
  logic             final_q;
  logic             out_valid_q;
  logic [WordW-1:0] f, k, t_sum, w_new, w_mix;
  logic             emit_go;

  assign pop_o   = (state_q == StLoad) && !empty_i;
  assign emit_go = !out_valid_q || !out_stall_i;

  always_comb begin
    priority if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
  end

  // window holds W[t..t+15]; W[t+16] comes from taps 13, 8, 2 and 0
  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];

  always_ff @(posedge clk_i) begin
    if (pop_o || state_q == StRound) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= (state_q == StRound) ? w_new : entry_i.word;
    end
    if (state_q == StEmit && emit_go) begin
      for (int i = 0; i < 5; i++) begin
        dig_q[i] <= h_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
      e_q         <= '0;
      h_q[0]      <= H0Init;
      h_q[1]      <= H1Init;
      h_q[2]      <= H2Init;
      h_q[3]      <= H3Init;
      h_q[4]      <= H4Init;
      rnd_q       <= '0;
      ld_cnt_q    <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StEmit && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (pop_o) begin
            ld_cnt_q <= ld_cnt_q + 4'd1;
            if (ld_cnt_q == 4'd15) begin
              final_q <= entry_i.is_final;
              a_q     <= h_q[0];
              b_q     <= h_q[1];
              c_q     <= h_q[2];
              d_q     <= h_q[3];
              e_q     <= h_q[4];
              rnd_q   <= '0;
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          a_q   <= t_sum;
          b_q   <= a_q;
          c_q   <= {b_q[1:0], b_q[31:2]};
          d_q   <= c_q;
          e_q   <= d_q;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          h_q[0]  <= h_q[0] + a_q;
          h_q[1]  <= h_q[1] + b_q;
          h_q[2]  <= h_q[2] + c_q;
          h_q[3]  <= h_q[3] + d_q;
          h_q[4]  <= h_q[4] + e_q;
          state_q <= final_q ? StEmit : StLoad;
        end
        default: begin
          // wait for the previous digest to leave before overwriting it
          if (emit_go) begin
            h_q[0]      <= H0Init;
            h_q[1]      <= H1Init;
            h_q[2]      <= H2Init;
            h_q[3]      <= H3Init;
            h_q[4]      <= H4Init;
            state_q     <= StLoad;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign digest_h0_o = dig_q[0];
  assign digest_h1_o = dig_q[1];
  assign digest_h2_o = dig_q[2];
  assign digest_h3_o = dig_q[3];
  assign digest_h4_o = dig_q[4];

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (rnd_q <= 7'd79))
    else $error("round counter out of range");

  a_emit_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && !out_valid_q) |=> (out_valid_q && state_q == StLoad))
    else $error("digest not presented");

endmodule

>>> rtl/sha1_hash.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 hash engine.
//
// Input channel: one message byte per item on message_byte_i, with last_byte_i
// set on the final byte of a message. An item is taken when in_valid_i is high
// and in_stall_o is low. After a last byte the input stalls while the padding
// and length words are queued, one a cycle whenever the queue has room.
// Output channel: one 160-bit digest per message on digest_h0_o..digest_h4_o,
// most significant word first, held while out_stall_i is high.
// Throughput: bytes enter at one per cycle until the four-word queue to the
// compression core fills; each 64-byte block costs 80 rounds and a fold into
// the chain in the core plus a load of 16 words, but the queue holds only 16
// bytes, so the other 48 arrive during the load at one a cycle.
// After the last byte, the padding words are queued at one a cycle while the
// queue has room, and the final one or two blocks are then compressed.
// A stalled digest does not block the core until a second digest is ready.
// Reset loads the standard initial chain words and clears all counters.
module sha1_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_h0_o,
  output logic [31:0] digest_h1_o,
  output logic [31:0] digest_h2_o,
  output logic [31:0] digest_h3_o,
  output logic [31:0] digest_h4_o
);
  import sha1_pkg::*;

  word_entry_t push_entry, pop_entry;
  logic        push, pop, full, empty;

  sha1_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_byte_i (message_byte_i),
    .last_byte_i    (last_byte_i),
    .push_o         (push),
    .push_entry_o   (push_entry),
    .fifo_full_i    (full)
  );

  sha1_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (empty)
  );

  sha1_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .digest_h0_o (digest_h0_o),
    .digest_h1_o (digest_h1_o),
    .digest_h2_o (digest_h2_o),
    .digest_h3_o (digest_h3_o),
    .digest_h4_o (digest_h4_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
